// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the parser top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge of i_clk, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/dtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtf_pkg
// Types, character codes and IEEE single arithmetic helpers for the decimal
// text to float parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

    localparam int FRACTION_STEPS_DEF = 64;
    localparam int EXPONENT_CAP_DEF   = 1023;
    localparam int POW_MIN_EXP        = 45;
    localparam int POW_MAX_EXP        = 38;
    localparam int POW_ENTRIES        = POW_MIN_EXP + POW_MAX_EXP + 1;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    localparam logic [31:0] FP_NAN  = 32'h7FC0_0000;
    localparam logic [31:0] FP_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP_TEN  = 32'h4120_0000;
    localparam logic [31:0] FP_TENTH = 32'h3DCC_CCCD;

    // Powers of ten from 10^-45 up to 10^38, as double literals
    localparam real POW_DECADES [POW_ENTRIES] = '{
        1e-45, 1e-44, 1e-43, 1e-42, 1e-41, 1e-40, 1e-39, 1e-38, 1e-37, 1e-36,
        1e-35, 1e-34, 1e-33, 1e-32, 1e-31, 1e-30, 1e-29, 1e-28, 1e-27, 1e-26,
        1e-25, 1e-24, 1e-23, 1e-22, 1e-21, 1e-20, 1e-19, 1e-18, 1e-17, 1e-16,
        1e-15, 1e-14, 1e-13, 1e-12, 1e-11, 1e-10, 1e-9, 1e-8, 1e-7, 1e-6,
        1e-5, 1e-4, 1e-3, 1e-2, 1e-1, 1e0, 1e1, 1e2, 1e3, 1e4,
        1e5, 1e6, 1e7, 1e8, 1e9, 1e10, 1e11, 1e12, 1e13, 1e14,
        1e15, 1e16, 1e17, 1e18, 1e19, 1e20, 1e21, 1e22, 1e23, 1e24,
        1e25, 1e26, 1e27, 1e28, 1e29, 1e30, 1e31, 1e32, 1e33, 1e34,
        1e35, 1e36, 1e37, 1e38};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    // Round to nearest even and pack; value = m * 2^(e - 176), m nonzero
    function automatic logic [31:0] round_pack(input logic s, input logic signed [12:0] e,
                                               input logic [49:0] m);
        logic [49:0] mm;
        logic [49:0] mask;
        logic signed [12:0] ee;
        logic [5:0] lz;
        logic [12:0] sh;
        logic sticky;
        logic [24:0] r;
        logic [31:0] pk;
        lz = '0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) lz = 6'(49 - i);
        end
        mm = m << lz;
        ee = e - 13'($unsigned(lz));
        sticky = 1'b0;
        if (ee < 13'sd1) begin
            sh = 13'(13'sd1 - ee);
            if (sh > 13'd50) sh = 13'd50;
            mask = (50'd1 << sh[5:0]) - 50'd1;
            if (sh == 13'd50) mask = '1;
            sticky = |(mm & mask);
            mm = (sh == 13'd50) ? '0 : (mm >> sh[5:0]);
            ee = 13'sd1;
        end
        sticky = sticky | (|mm[24:0]);
        r = {1'b0, mm[49:26]} + 25'(mm[25] & (sticky | mm[26]));
        if (ee > 13'sd254) begin
            pk = {s, FP_INF[30:0]};
        end else begin
            pk = ({24'd0, 8'(ee[7:0] - 8'd1)} << 23) + {7'd0, r};
            pk = {s, pk[30:0]};
        end
        return pk;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [12:0] e;
        logic [31:0] res;
        s = a[31] ^ b[31];
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        zero_a = (a[30:0] == '0);
        zero_b = (b[30:0] == '0);
        ma = {a[30:23] != 8'h00, a[22:0]};
        mb = {b[30:23] != 8'h00, b[22:0]};
        p = 48'(ma) * 48'(mb);
        e = 13'($unsigned((a[30:23] == 8'h00) ? 8'd1 : a[30:23]))
          + 13'($unsigned((b[30:23] == 8'h00) ? 8'd1 : b[30:23])) - 13'sd126;
        if (nan_a || nan_b) begin
            res = FP_NAN;
        end else if (inf_a || inf_b) begin
            res = (zero_a || zero_b) ? FP_NAN : {s, FP_INF[30:0]};
        end else if (zero_a || zero_b) begin
            res = {s, 31'd0};
        end else begin
            res = round_pack(s, e, {p, 2'b00});
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [31:0] x, y;
        logic [7:0] ex, ey, diff;
        logic [49:0] xm, ym, mask, sum;
        logic [31:0] res;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        zero_a = (a[30:0] == '0);
        zero_b = (b[30:0] == '0);
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'h00) ? 8'd1 : y[30:23];
        diff = ex - ey;
        xm = {1'b0, x[30:23] != 8'h00, x[22:0], 25'd0};
        ym = {1'b0, y[30:23] != 8'h00, y[22:0], 25'd0};
        if (diff >= 8'd50) begin
            ym = 50'd1;
        end else begin
            mask = (50'd1 << diff[5:0]) - 50'd1;
            ym = (ym >> diff[5:0]) | 50'(|(ym & mask));
        end
        sum = (x[31] == y[31]) ? (xm + ym) : (xm - ym);
        if (nan_a || nan_b) begin
            res = FP_NAN;
        end else if (inf_a && inf_b) begin
            res = (a[31] != b[31]) ? FP_NAN : a;
        end else if (inf_a) begin
            res = a;
        end else if (inf_b) begin
            res = b;
        end else if (zero_a && zero_b) begin
            res = {a[31] & b[31], 31'd0};
        end else if (zero_a) begin
            res = b;
        end else if (zero_b) begin
            res = a;
        end else if (sum == '0) begin
            res = '0;
        end else begin
            res = round_pack(x[31], 13'($unsigned(ex)) + 13'sd1, sum);
        end
        return res;
    endfunction

    function automatic logic [31:0] digit_float(input logic [3:0] d);
        logic [31:0] f;
        case (d)
            4'd1:    f = 32'h3F80_0000;
            4'd2:    f = 32'h4000_0000;
            4'd3:    f = 32'h4040_0000;
            4'd4:    f = 32'h4080_0000;
            4'd5:    f = 32'h40A0_0000;
            4'd6:    f = 32'h40C0_0000;
            4'd7:    f = 32'h40E0_0000;
            4'd8:    f = 32'h4100_0000;
            4'd9:    f = 32'h4110_0000;
            default: f = 32'h0000_0000;
        endcase
        return f;
    endfunction

    // Elaboration-time helpers for the constant tables
    function automatic logic [31:0] dbl_to_flt(input logic [63:0] d);
        logic [52:0] m53;
        logic [49:0] m50;
        logic signed [12:0] e;
        logic [31:0] res;
        m53 = {1'b1, d[51:0]};
        m50 = {m53[52:4], m53[3] | (|m53[2:0])};
        e = 13'($unsigned(d[62:52])) - 13'sd896;
        if (d[62:52] == 11'd0) res = {d[63], 31'd0};
        else                   res = round_pack(d[63], e, m50);
        return res;
    endfunction

    function automatic real flt_to_real(input logic [31:0] f);
        real r;
        int sc;
        if (f[30:23] == 8'h00) begin
            r = f[22:0];
            sc = -149;
        end else begin
            r = {1'b1, f[22:0]};
            sc = int'(f[30:23]) - 150;
        end
        while (sc > 0) begin
            r = r * 2.0;
            sc = sc - 1;
        end
        while (sc < 0) begin
            r = r * 0.5;
            sc = sc + 1;
        end
        return r;
    endfunction

    function automatic logic [31:0] factor_bits(input int idx, input int steps);
        logic [31:0] fb;
        fb = FP_TENTH;
        for (int i = 0; i < idx; i++) begin
            fb = dbl_to_flt($realtobits(flt_to_real(fb) * 0.1));
        end
        if (idx == steps - 1) fb = '0;
        return fb;
    endfunction

    function automatic logic [31:0] pow_bits(input int k);
        return dbl_to_flt($realtobits(POW_DECADES[k + POW_MIN_EXP]));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/decimal_text_to_float_parser_top.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_float_parser_top
// Parses decimal text, one character per item, into an IEEE single value.
// ----------------------------------------------------------------------------
// A character item is handled in idle; a mantissa or fraction digit steps
// through multiply, add and back to idle in the one shared float multiply/add
// unit; an end item adds the final scale multiply. The input is not ready
// while a digit or the final scale multiply is in the unit or a result waits
// on the output. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module decimal_text_to_float_parser_top
    import dtf_pkg::*;
#(
    parameter int FRACTION_STEPS = FRACTION_STEPS_DEF,
    parameter int EXPONENT_CAP   = EXPONENT_CAP_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_char_code,
    input  wire         i_has_char,
    input  wire         i_end_of_string,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_parse_ok,
    output logic [31:0] o_value_bits
);

    localparam int FC_W = $clog2(FRACTION_STEPS);
    localparam int EX_W = $clog2(EXPONENT_CAP + 1);

    logic [31:0] factor_rom [FRACTION_STEPS];
    logic [31:0] pow_rom [POW_ENTRIES];

    for (genvar g = 0; g < FRACTION_STEPS; g++) begin : g_factor
        localparam logic [31:0] FACTOR_VAL = factor_bits(g, FRACTION_STEPS);
        assign factor_rom[g] = FACTOR_VAL;
    end

    for (genvar g = 0; g < POW_ENTRIES; g++) begin : g_pow
        localparam logic [31:0] POW_VAL = pow_bits(g - POW_MIN_EXP);
        assign pow_rom[g] = POW_VAL;
    end

    t_state r_state, n_state;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_opa, n_opa;
    logic [31:0] r_opb, n_opb;
    logic [31:0] r_tmp, n_tmp;
    logic [31:0] r_digf, n_digf;
    logic        r_frac_mode, n_frac_mode;
    logic        r_last, n_last;
    logic [FC_W-1:0] r_frac_cnt, n_frac_cnt;
    logic [EX_W-1:0] r_exp, n_exp;
    logic r_empty, n_empty, r_neg, n_neg, r_dot, n_dot, r_expf, n_expf;
    logic r_exp_neg, n_exp_neg, r_exp_sign, n_exp_sign, r_failed, n_failed;
    logic        r_out_valid, n_out_valid;
    logic        r_out_ok, n_out_ok;
    logic [31:0] r_out_bits, n_out_bits;

    logic [31:0] w_unit_a, w_unit_b, w_unit_res, w_signed_acc, w_scale;
    logic        w_unit_add;
    logic        w_accept, w_is_digit, w_ok;
    logic [3:0]  w_digit;
    logic [EX_W+3:0] w_exp_next;
    logic [6:0]  w_pow_idx;

    assign o_in_ready   = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid  = r_out_valid;
    assign o_parse_ok   = r_out_ok;
    assign o_value_bits = r_out_bits;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_is_digit   = i_char_code inside {[CH_ZERO:CH_NINE]};
    assign w_digit      = 4'(i_char_code - CH_ZERO);
    assign w_exp_next   = (EX_W + 4)'(r_exp) * (EX_W + 4)'(10) + (EX_W + 4)'(w_digit);
    assign w_signed_acc = {r_acc[31] ^ r_neg, r_acc[30:0]};
    assign w_ok         = !r_failed && !r_empty;

    always_comb begin
        w_pow_idx = r_exp_neg ? 7'(POW_MIN_EXP - int'(r_exp[$clog2(POW_MIN_EXP + 1)-1:0]))
                              : 7'(POW_MIN_EXP + int'(r_exp[$clog2(POW_MAX_EXP + 1)-1:0]));
        if (!r_exp_neg && (r_exp > EX_W'(POW_MAX_EXP)))     w_scale = FP_INF;
        else if (r_exp_neg && (r_exp > EX_W'(POW_MIN_EXP))) w_scale = '0;
        else                                                w_scale = pow_rom[w_pow_idx];
    end

    // Shared float unit
    always_comb begin
        w_unit_add = 1'b0;
        w_unit_a   = r_opa;
        w_unit_b   = r_opb;
        case (r_state)
            ST_ADD: begin
                w_unit_add = 1'b1;
                w_unit_a   = r_tmp;
                w_unit_b   = r_frac_mode ? r_acc : r_digf;
            end
            ST_FIN: begin
                w_unit_a = w_signed_acc;
                w_unit_b = w_scale;
            end
            default: ;
        endcase
        w_unit_res = w_unit_add ? fp_add(w_unit_a, w_unit_b) : fp_mul(w_unit_a, w_unit_b);
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_tmp       = r_tmp;
        n_digf      = r_digf;
        n_frac_mode = r_frac_mode;
        n_last      = r_last;
        n_frac_cnt  = r_frac_cnt;
        n_exp       = r_exp;
        n_empty     = r_empty;
        n_neg       = r_neg;
        n_dot       = r_dot;
        n_expf      = r_expf;
        n_exp_neg   = r_exp_neg;
        n_exp_sign  = r_exp_sign;
        n_failed    = r_failed;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_ok    = r_out_ok;
        n_out_bits  = r_out_bits;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last  = i_end_of_string;
                    n_state = i_end_of_string ? ST_FIN : ST_IDLE;
                    if (i_has_char && !r_failed) begin
                        if ((i_char_code == CH_MINUS) && r_empty) begin
                            n_empty = 1'b0;
                            n_neg   = 1'b1;
                        end else if (i_char_code == CH_DOT) begin
                            if (r_dot) n_failed = 1'b1;
                            else       n_dot    = 1'b1;
                        end else if (w_is_digit) begin
                            n_empty = 1'b0;
                            n_digf  = digit_float(w_digit);
                            if (r_dot) begin
                                n_frac_mode = 1'b1;
                                n_opa       = factor_rom[r_frac_cnt];
                                n_opb       = digit_float(w_digit);
                                n_state     = ST_MUL;
                                if (r_frac_cnt != FC_W'(FRACTION_STEPS - 1))
                                    n_frac_cnt = r_frac_cnt + 1'b1;
                            end else if (r_expf) begin
                                n_exp = (w_exp_next > (EX_W + 4)'(EXPONENT_CAP))
                                      ? EX_W'(EXPONENT_CAP) : EX_W'(w_exp_next);
                            end else begin
                                n_frac_mode = 1'b0;
                                n_opa       = r_acc;
                                n_opb       = FP_TEN;
                                n_state     = ST_MUL;
                            end
                        end else if (((i_char_code == CH_PLUS) || (i_char_code == CH_MINUS))
                                     && r_expf) begin
                            if (r_exp_sign) begin
                                n_failed = 1'b1;
                            end else begin
                                n_exp_sign = 1'b1;
                                if (i_char_code == CH_MINUS) n_exp_neg = 1'b1;
                            end
                        end else if ((i_char_code == CH_E_LO) || (i_char_code == CH_E_UP)) begin
                            if (r_expf) begin
                                n_failed = 1'b1;
                            end else begin
                                n_expf = 1'b1;
                                n_dot  = 1'b0;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
            end
            ST_MUL: begin
                n_tmp   = w_unit_res;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_acc   = w_unit_res;
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                n_out_valid = 1'b1;
                n_out_ok    = w_ok;
                n_out_bits  = !w_ok ? '0 : (r_expf ? w_unit_res : w_signed_acc);
                n_state     = ST_IDLE;
                // drop the text state for the next number
                n_acc      = '0;
                n_frac_cnt = '0;
                n_exp      = '0;
                n_empty    = 1'b1;
                n_neg      = 1'b0;
                n_dot      = 1'b0;
                n_expf     = 1'b0;
                n_exp_neg  = 1'b0;
                n_exp_sign = 1'b0;
                n_failed   = 1'b0;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_frac_cnt  <= '0;
            r_exp       <= '0;
            r_empty     <= 1'b1;
            r_neg       <= 1'b0;
            r_dot       <= 1'b0;
            r_expf      <= 1'b0;
            r_exp_neg   <= 1'b0;
            r_exp_sign  <= 1'b0;
            r_failed    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_frac_cnt  <= n_frac_cnt;
            r_exp       <= n_exp;
            r_empty     <= n_empty;
            r_neg       <= n_neg;
            r_dot       <= n_dot;
            r_expf      <= n_expf;
            r_exp_neg   <= n_exp_neg;
            r_exp_sign  <= n_exp_sign;
            r_failed    <= n_failed;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa       <= n_opa;
        r_opb       <= n_opb;
        r_tmp       <= n_tmp;
        r_digf      <= n_digf;
        r_frac_mode <= n_frac_mode;
        r_out_ok    <= n_out_ok;
        r_out_bits  <= n_out_bits;
    end

    `ASSERT_CLK(a_state_onehot, $onehot(r_state), "state register not one-hot")
    `ASSERT_CLK(a_fin_gives_item, r_state == ST_FIN |=> r_out_valid, "no item after finish")
    `ASSERT_CLK(a_fail_zero, (r_out_valid && !r_out_ok) |-> (r_out_bits == '0), "failed item not zero")
    `ASSERT_CLK(a_exp_capped, r_exp <= EX_W'(EXPONENT_CAP), "exponent count above cap")

endmodule

`default_nettype wire
